@@ hdl/qvr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and widths for the quaternion vector rotator.
// No dependencies; used by qvr_dot and quaternion_vector_rotate.
package qvr_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int VEC_WIDTH      = 32;
    localparam int QUAT_WIDTH     = QUAT_FRAC_BITS + 2;
    localparam int PAIR_WIDTH     = 2 * QUAT_WIDTH;
    // matrix entry: sum of four pair products, or twice a sum of two
    localparam int ENTRY_WIDTH    = 2 * QUAT_WIDTH + 2;
    localparam int RESCALE_SHIFT  = 2 * QUAT_FRAC_BITS;
    localparam int PROD_WIDTH     = ENTRY_WIDTH + VEC_WIDTH;
    localparam int ACC_WIDTH      = PROD_WIDTH + 2;

    typedef enum logic {
        OP_ROTATE  = 1'b0,
        OP_INVERSE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                           opcode;
        logic signed [QUAT_WIDTH-1:0]  quat_w;
        logic signed [QUAT_WIDTH-1:0]  quat_x;
        logic signed [QUAT_WIDTH-1:0]  quat_y;
        logic signed [QUAT_WIDTH-1:0]  quat_z;
        logic signed [VEC_WIDTH-1:0]   vec_x;
        logic signed [VEC_WIDTH-1:0]   vec_y;
        logic signed [VEC_WIDTH-1:0]   vec_z;
    } t_cmd;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0]   out_x;
        logic signed [VEC_WIDTH-1:0]   out_y;
        logic signed [VEC_WIDTH-1:0]   out_z;
        logic                          saturated;
    } t_result;

    typedef logic [2:0][ENTRY_WIDTH-1:0] t_row;
    typedef logic [2:0][VEC_WIDTH-1:0]   t_vec;
    typedef logic signed [ACC_WIDTH-1:0] t_acc;

endpackage

@@ hdl/qvr_dot.sv @@
`timescale 1ns / 1ps
// One row of the rotation matrix times the vector, three register stages.
// Depends on qvr_pkg.
module qvr_dot (
    input  logic            i_clk,
    input  qvr_pkg::t_row   i_row,
    input  qvr_pkg::t_vec   i_vec,
    output qvr_pkg::t_acc   o_sum
);

    localparam int EW  = qvr_pkg::ENTRY_WIDTH;
    localparam int VW  = qvr_pkg::VEC_WIDTH;
    localparam int LOW = VW / 2;
    localparam int HIW = VW - LOW;
    localparam int PLW = EW + LOW + 1;
    localparam int PHW = EW + HIW;
    localparam int FW  = qvr_pkg::PROD_WIDTH;
    localparam int AW  = qvr_pkg::ACC_WIDTH;
    localparam logic signed [AW-1:0] HALF_LSB = AW'(1) <<< (qvr_pkg::RESCALE_SHIFT - 1);

    logic signed [PLW-1:0] r_pl   [3];
    logic signed [PHW-1:0] r_ph   [3];
    logic signed [FW-1:0]  r_prod [3];
    logic signed [AW-1:0]  r_sum;

    // split each vector word so every multiplier stays near 32 bits wide
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_pl[k] <= $signed(i_row[k]) * $signed({1'b0, i_vec[k][LOW-1:0]});
            r_ph[k] <= $signed(i_row[k]) * $signed(i_vec[k][VW-1:LOW]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= (FW'(r_ph[k]) <<< LOW) + FW'(r_pl[k]);
        end
    end

    // fold in half an output LSB for round to nearest
    always_ff @(posedge i_clk) begin
        r_sum <= AW'(r_prod[0]) + AW'(r_prod[1]) + AW'(r_prod[2]) + HALF_LSB;
    end

    assign o_sum = r_sum;

endmodule

@@ hdl/quaternion_vector_rotate.sv @@
`timescale 1ns / 1ps
// Quaternion vector rotator: returns q*v*conj(q), or conj(q)*v*q on inverse.
// Quaternion components are signed Q1.14, vector components signed Q16.16.
// Usage:
//   Present a command on i_cmd and raise start; the beat is taken at the
//   rising edge where start is high and busy is low. opcode OP_INVERSE
//   negates the quaternion's vector part before rotating.
//   The result appears on o_result with o_valid high for exactly one cycle,
//   once the command has passed through the pipeline stages named below.
//   The receiver has no hold-off.
//   Throughput: one command per cycle while busy is low. The datapath is a
//   six-stage pipeline: pair products, matrix entries, split partial
//   products, full products, row sums with rounding, and the saturating
//   output register.
//   A non-unit quaternion scales the result by its squared length. A
//   component outside the Q16.16 range clips to the range limit and sets
//   saturated.
//   Reset (synchronous, active low) empties the pipeline; busy is high during
//   reset and in the cycle after it, and low from then on.
module quaternion_vector_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  qvr_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    output qvr_pkg::t_result   o_result
);

    localparam int PW  = qvr_pkg::PAIR_WIDTH;
    localparam int EW  = qvr_pkg::ENTRY_WIDTH;
    localparam int VW  = qvr_pkg::VEC_WIDTH;
    localparam int AW  = qvr_pkg::ACC_WIDTH;
    localparam int RS  = qvr_pkg::RESCALE_SHIFT;
    localparam int NV  = 5;
    localparam logic [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};

    logic                 r_live;
    logic [NV-1:0]        r_vld;
    logic                 r_out_vld;
    qvr_pkg::t_result     r_result;
    logic                 s_accept;
    logic                 s_inv;

    logic signed [PW-1:0] n_ww, n_xx, n_yy, n_zz, n_xy, n_xz, n_yz, n_wx, n_wy, n_wz;
    logic signed [PW-1:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qvr_pkg::t_vec        r_vec_a, r_vec_b;
    qvr_pkg::t_row        r_row [3];
    qvr_pkg::t_acc        s_sum [3];

    logic [VW-1:0]        n_comp [3];
    logic [2:0]           n_clip;

    assign busy     = !r_live;
    assign s_accept = start && !busy;
    assign s_inv    = (i_cmd.opcode == qvr_pkg::OP_INVERSE);

    // control: valid bits ride along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= 1'b0;
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_live    <= 1'b1;
            r_vld     <= {r_vld[NV-2:0], s_accept};
            r_out_vld <= r_vld[NV-1];
        end
    end

    // stage A: ten pairwise products; inverse flips the sign of the w-cross pairs
    always_comb begin
        n_ww = $signed(i_cmd.quat_w) * $signed(i_cmd.quat_w);
        n_xx = $signed(i_cmd.quat_x) * $signed(i_cmd.quat_x);
        n_yy = $signed(i_cmd.quat_y) * $signed(i_cmd.quat_y);
        n_zz = $signed(i_cmd.quat_z) * $signed(i_cmd.quat_z);
        n_xy = $signed(i_cmd.quat_x) * $signed(i_cmd.quat_y);
        n_xz = $signed(i_cmd.quat_x) * $signed(i_cmd.quat_z);
        n_yz = $signed(i_cmd.quat_y) * $signed(i_cmd.quat_z);
        n_wx = $signed(i_cmd.quat_w) * $signed(i_cmd.quat_x);
        n_wy = $signed(i_cmd.quat_w) * $signed(i_cmd.quat_y);
        n_wz = $signed(i_cmd.quat_w) * $signed(i_cmd.quat_z);
        if (s_inv) begin
            n_wx = -n_wx;
            n_wy = -n_wy;
            n_wz = -n_wz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ww    <= n_ww;
        r_xx    <= n_xx;
        r_yy    <= n_yy;
        r_zz    <= n_zz;
        r_xy    <= n_xy;
        r_xz    <= n_xz;
        r_yz    <= n_yz;
        r_wx    <= n_wx;
        r_wy    <= n_wy;
        r_wz    <= n_wz;
        r_vec_a <= {i_cmd.vec_z, i_cmd.vec_y, i_cmd.vec_x};
    end

    // stage B: rotation matrix entries, off-diagonals carry the factor of two
    always_ff @(posedge i_clk) begin
        r_row[0][0] <= EW'(r_ww) + EW'(r_xx) - EW'(r_yy) - EW'(r_zz);
        r_row[0][1] <= (EW'(r_xy) - EW'(r_wz)) <<< 1;
        r_row[0][2] <= (EW'(r_xz) + EW'(r_wy)) <<< 1;
        r_row[1][0] <= (EW'(r_xy) + EW'(r_wz)) <<< 1;
        r_row[1][1] <= EW'(r_ww) - EW'(r_xx) + EW'(r_yy) - EW'(r_zz);
        r_row[1][2] <= (EW'(r_yz) - EW'(r_wx)) <<< 1;
        r_row[2][0] <= (EW'(r_xz) - EW'(r_wy)) <<< 1;
        r_row[2][1] <= (EW'(r_yz) + EW'(r_wx)) <<< 1;
        r_row[2][2] <= EW'(r_ww) - EW'(r_xx) - EW'(r_yy) + EW'(r_zz);
        r_vec_b     <= r_vec_a;
    end

    // stages C to E: one dot product per output component
    for (genvar g = 0; g < 3; g++) begin : g_row
        qvr_dot u_dot (
            .i_clk (i_clk),
            .i_row (r_row[g]),
            .i_vec (r_vec_b),
            .o_sum (s_sum[g])
        );
    end

    // output stage: drop the rescale bits and clip to the vector range
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ((&s_sum[k][AW-1:RS+VW-1]) || !(|s_sum[k][AW-1:RS+VW-1])) begin
                n_clip[k] = 1'b0;
                n_comp[k] = s_sum[k][RS+VW-1:RS];
            end else begin
                n_clip[k] = 1'b1;
                n_comp[k] = s_sum[k][AW-1] ? VEC_MIN : VEC_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.out_x     <= n_comp[0];
        r_result.out_y     <= n_comp[1];
        r_result.out_z     <= n_comp[2];
        r_result.saturated <= |n_clip;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_result;

    // every accepted beat must be followed by o_valid at the pipeline output
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> ##6 o_valid)
        else $error("accepted beat produced no result");

    // a saturated result must hold at least one component at a range limit
    a_sat_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.out_x == VEC_MAX || o_result.out_x == VEC_MIN ||
             o_result.out_y == VEC_MAX || o_result.out_y == VEC_MIN ||
             o_result.out_z == VEC_MAX || o_result.out_z == VEC_MIN))
        else $error("saturated flag without a clipped component");

    // once r_live is set after reset the pipeline never refuses a command
    a_no_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule
